/* design/sha1mh_pkg.sv */
// Package with the shared types and constants of the SHA-1 message hasher.
`timescale 1ns / 1ps

package sha1mh_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } result_t;

    typedef logic [4:0][31:0] chain_t;

    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       start;
        logic       reinit;
    } ctrl_t;

    typedef struct packed {
        logic done;
    } stat_t;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hc3d2e1f0;

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [7:0] PAD_ZERO   = 8'h00;
    localparam logic [2:0] LAST_INDEX = 3'd4;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] LEN_START  = 6'd56;

endpackage

/* design/sha1mh_core.sv */
// Block buffer and iterative SHA-1 compression engine, one round per cycle.
`timescale 1ns / 1ps

module sha1mh_core (
    input  logic               clk,
    input  logic               rst_n,
    input  sha1mh_pkg::ctrl_t  ctrl,
    output sha1mh_pkg::stat_t  stat,
    output sha1mh_pkg::chain_t chain
);
    import sha1mh_pkg::*;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_ADD
    } cstate_t;

    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [6:0] ROUND_B1   = 7'd20;
    localparam logic [6:0] ROUND_B2   = 7'd40;
    localparam logic [6:0] ROUND_B3   = 7'd60;

    cstate_t      cstate_reg;
    logic [6:0]   round_reg;
    logic         done_reg;
    chain_t       h_reg;
    logic [511:0] buf_reg;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;

    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;
    logic [31:0] w_new;

    always_comb
    begin
        if (round_reg < ROUND_B1)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K0;
        end
        else if (round_reg < ROUND_B2)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end
        else if (round_reg < ROUND_B3)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + buf_reg[511:480];

    always_comb
    begin
        logic [31:0] x;
        x = buf_reg[95:64] ^ buf_reg[255:224] ^ buf_reg[447:416] ^ buf_reg[511:480];
        w_new = {x[30:0], x[31]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cstate_reg <= C_IDLE;
            round_reg  <= '0;
            done_reg   <= 1'b0;
            h_reg      <= {IV4, IV3, IV2, IV1, IV0};
        end
        else
        begin
            done_reg <= (cstate_reg == C_ADD);
            unique case (cstate_reg)
                C_IDLE:
                begin
                    if (ctrl.reinit)
                    begin
                        h_reg <= {IV4, IV3, IV2, IV1, IV0};
                    end
                    if (ctrl.start)
                    begin
                        round_reg  <= '0;
                        cstate_reg <= C_ROUND;
                    end
                end
                C_ROUND:
                begin
                    round_reg <= round_reg + 7'd1;
                    if (round_reg == ROUND_LAST)
                    begin
                        cstate_reg <= C_ADD;
                    end
                end
                C_ADD:
                begin
                    h_reg[0]   <= h_reg[0] + a_reg;
                    h_reg[1]   <= h_reg[1] + b_reg;
                    h_reg[2]   <= h_reg[2] + c_reg;
                    h_reg[3]   <= h_reg[3] + d_reg;
                    h_reg[4]   <= h_reg[4] + e_reg;
                    cstate_reg <= C_IDLE;
                end
                default:
                begin
                    cstate_reg <= C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cstate_reg == C_IDLE)
        begin
            if (ctrl.push)
            begin
                buf_reg <= {buf_reg[503:0], ctrl.push_byte};
            end
            if (ctrl.start)
            begin
                a_reg <= h_reg[0];
                b_reg <= h_reg[1];
                c_reg <= h_reg[2];
                d_reg <= h_reg[3];
                e_reg <= h_reg[4];
            end
        end
        else if (cstate_reg == C_ROUND)
        begin
            a_reg   <= t_val;
            b_reg   <= a_reg;
            c_reg   <= {b_reg[1:0], b_reg[31:2]};
            d_reg   <= c_reg;
            e_reg   <= d_reg;
            buf_reg <= {buf_reg[479:0], w_new};
        end
    end

    assign stat.done = done_reg;
    assign chain     = h_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> cstate_reg == C_IDLE)
        else $error("Compression started while the engine was busy.");

    a_done_after_add: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(cstate_reg == C_ADD))
        else $error("Done raised without a final chaining update.");

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        cstate_reg == C_ROUND |-> round_reg <= ROUND_LAST)
        else $error("Round counter ran past the last round.");
`endif

endmodule

/* design/sha1_message_hasher_unit.sv */
// Top level of the SHA-1 message hasher: byte gathering, padding and digest output.
//
// Usage: message bytes arrive on the item channel, one per transfer, with
// byte_valid marking a real byte and end_of_message closing the message.
// The five digest words leave on the result channel, H0 first, with
// word_index 0 to 4 and last_word set on the fifth.
// Throughput: a byte is taken every cycle while the 64-byte block buffer
// fills. The transfer that completes a block starts a compression, and
// item_stall stays high while the single round unit runs all rounds and
// then the chaining update. At end of message the padding bytes are
// shifted in one per cycle, over one block or over two when a second
// block is needed, each block is compressed, and the digest appears once
// the last compression has finished.
// A result waits on result_stall without change; no new item is taken until
// the fifth word has been transferred, after which the chaining value and
// the byte count return to their initial values.
// Reset loads the standard initial chaining value and clears all counters.
`timescale 1ns / 1ps

module sha1_message_hasher_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  sha1mh_pkg::item_t   item,
    input  logic                item_valid,
    output logic                item_stall,
    output sha1mh_pkg::result_t result,
    output logic                result_valid,
    input  logic                result_stall
);
    import sha1mh_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMP,
        S_PAD,
        S_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] count_reg, count_next;
    logic        pad_reg, pad_next;
    logic        mark_reg, mark_next;
    logic        wrap_reg, wrap_next;
    logic        final_reg, final_next;
    logic [2:0]  widx_reg, widx_next;

    ctrl_t       ctrl;
    stat_t       stat;
    chain_t      chain;
    logic [63:0] len_shift;
    logic        len_sel;

    sha1mh_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat),
        .chain (chain)
    );

    assign len_shift = {count_reg, 3'b000} << {fill_reg[2:0], 3'b000};
    assign len_sel   = mark_reg && !wrap_reg && (fill_reg >= LEN_START);

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        pad_next       = pad_reg;
        mark_next      = mark_reg;
        wrap_next      = wrap_reg;
        final_next     = final_reg;
        widx_next      = widx_reg;
        ctrl.push      = 1'b0;
        ctrl.push_byte = item.data_byte;
        ctrl.start     = 1'b0;
        ctrl.reinit    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.byte_valid)
                    begin
                        ctrl.push  = 1'b1;
                        fill_next  = fill_reg + 6'd1;
                        count_next = count_reg + 61'd1;
                        if (fill_reg == FILL_LAST)
                        begin
                            ctrl.start = 1'b1;
                            pad_next   = item.end_of_message;
                            state_next = S_COMP;
                        end
                        else if (item.end_of_message)
                        begin
                            pad_next   = 1'b1;
                            state_next = S_PAD;
                        end
                    end
                    else if (item.end_of_message)
                    begin
                        pad_next   = 1'b1;
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                ctrl.push = 1'b1;
                fill_next = fill_reg + 6'd1;
                if (!mark_reg)
                begin
                    ctrl.push_byte = PAD_MARK;
                    mark_next      = 1'b1;
                    wrap_next      = (fill_reg >= LEN_START);
                end
                else if (len_sel)
                begin
                    ctrl.push_byte = len_shift[63:56];
                end
                else
                begin
                    ctrl.push_byte = PAD_ZERO;
                end
                if (fill_reg == FILL_LAST)
                begin
                    ctrl.start = 1'b1;
                    wrap_next  = 1'b0;
                    final_next = len_sel;
                    state_next = S_COMP;
                end
            end
            S_COMP:
            begin
                if (stat.done)
                begin
                    if (final_reg)
                    begin
                        widx_next  = '0;
                        state_next = S_OUT;
                    end
                    else if (pad_reg)
                    begin
                        state_next = S_PAD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_OUT:
            begin
                if (!result_stall)
                begin
                    if (widx_reg == LAST_INDEX)
                    begin
                        ctrl.reinit = 1'b1;
                        fill_next   = '0;
                        count_next  = '0;
                        pad_next    = 1'b0;
                        mark_next   = 1'b0;
                        wrap_next   = 1'b0;
                        final_next  = 1'b0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        widx_next = widx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            count_reg <= '0;
            pad_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            wrap_reg  <= 1'b0;
            final_reg <= 1'b0;
            widx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
            pad_reg   <= pad_next;
            mark_reg  <= mark_next;
            wrap_reg  <= wrap_next;
            final_reg <= final_next;
            widx_reg  <= widx_next;
        end
    end

    assign item_stall         = (state_reg != S_IDLE);
    assign result_valid       = (state_reg == S_OUT);
    assign result.digest_word = chain[widx_reg];
    assign result.word_index  = widx_reg;
    assign result.last_word   = (widx_reg == LAST_INDEX);

`ifndef SYNTHESIS
    a_widx_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> widx_reg <= LAST_INDEX)
        else $error("Digest word index out of range.");

    a_done_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> state_reg == S_COMP)
        else $error("Compression finished outside the wait state.");

    a_clear_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && result.last_word
        |=> fill_reg == '0 && count_reg == '0 && state_reg == S_IDLE)
        else $error("State not cleared after the final digest transfer.");

    a_wrap_after_mark: assert property (@(posedge clk) disable iff (!rst_n)
        wrap_reg |-> mark_reg && state_reg == S_PAD)
        else $error("Padding wrap set without the end marker in place.");
`endif

endmodule

/* tb/tb_sha1_message_hasher_unit.sv */
// Self-checking testbench for the SHA-1 message hasher, with a built-in SHA-1 model.
`timescale 1ns / 1ps

module tb_sha1_message_hasher_unit;

    import sha1mh_pkg::*;

    localparam int BLOCK_BYTES  = 64;
    localparam int LENGTH_AT    = 56;
    localparam int RANDOM_ITEMS = 440;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 300;
    localparam int PLAN_ROWS    = 12;

    typedef struct packed {
        item_t        it;
        logic         known;
        logic [159:0] digest;
    } plan_row_t;

    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{'{8'h00, 1'b0, 1'b1}, 1'b1, 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709},
        '{'{8'h61, 1'b1, 1'b0}, 1'b0, 160'h0},
        '{'{8'hff, 1'b0, 1'b0}, 1'b0, 160'h0},
        '{'{8'h62, 1'b1, 1'b0}, 1'b0, 160'h0},
        '{'{8'h63, 1'b1, 1'b1}, 1'b1, 160'ha9993e364706816aba3e25717850c26c9cd0d89d},
        '{'{8'h00, 1'b0, 1'b1}, 1'b1, 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709},
        '{'{8'h00, 1'b1, 1'b1}, 1'b0, 160'h0},
        '{'{8'hff, 1'b1, 1'b1}, 1'b0, 160'h0},
        '{'{8'hff, 1'b1, 1'b0}, 1'b0, 160'h0},
        '{'{8'h00, 1'b1, 1'b0}, 1'b0, 160'h0},
        '{'{8'ha5, 1'b0, 1'b0}, 1'b0, 160'h0},
        '{'{8'h00, 1'b0, 1'b1}, 1'b0, 160'h0}
    };

    logic    clk;
    logic    rst_n;
    item_t   item;
    logic    item_valid;
    logic    item_stall;
    result_t result;
    logic    result_valid;
    logic    result_stall;

    logic [31:0] chain_model [5];
    logic [7:0]  block_model [BLOCK_BYTES];
    int          fill_model;
    logic [60:0] bytes_model;
    result_t     pending_digest [$];

    int unsigned errors;
    int unsigned idle_cycles;
    int unsigned stall_left;
    int unsigned roll;
    bit          calm;
    result_t     want;

    sha1_message_hasher_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void sha1_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        int i;
        for (i = 0; i < 16; i++)
        begin
            w[i] = {block_model[4*i], block_model[4*i+1], block_model[4*i+2],
                    block_model[4*i+3]};
        end
        for (i = 16; i < 80; i++)
        begin
            t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
            w[i] = {t[30:0], t[31]};
        end
        a = chain_model[0];
        b = chain_model[1];
        c = chain_model[2];
        d = chain_model[3];
        e = chain_model[4];
        for (i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = K0;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = K1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[i];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_model[0] += a;
        chain_model[1] += b;
        chain_model[2] += c;
        chain_model[3] += d;
        chain_model[4] += e;
    endfunction

    function automatic void sha1_restart();
        chain_model[0] = IV0;
        chain_model[1] = IV1;
        chain_model[2] = IV2;
        chain_model[3] = IV3;
        chain_model[4] = IV4;
        fill_model = 0;
        bytes_model = '0;
    endfunction

    function automatic void sha1_absorb(input item_t it);
        logic [63:0] bit_length;
        result_t     r;
        int          i;
        if (it.byte_valid)
        begin
            block_model[fill_model] = it.data_byte;
            fill_model++;
            bytes_model++;
            if (fill_model == BLOCK_BYTES)
            begin
                sha1_compress();
                fill_model = 0;
            end
        end
        if (!it.end_of_message)
            return;
        bit_length = {bytes_model, 3'b000};
        block_model[fill_model] = PAD_MARK;
        fill_model++;
        if (fill_model > LENGTH_AT)
        begin
            while (fill_model < BLOCK_BYTES)
            begin
                block_model[fill_model] = PAD_ZERO;
                fill_model++;
            end
            sha1_compress();
            fill_model = 0;
        end
        while (fill_model < LENGTH_AT)
        begin
            block_model[fill_model] = PAD_ZERO;
            fill_model++;
        end
        for (i = 0; i < 8; i++)
            block_model[BLOCK_BYTES - 1 - i] = bit_length[8*i +: 8];
        sha1_compress();
        for (i = 0; i < 5; i++)
        begin
            r.digest_word = chain_model[i];
            r.word_index  = 3'(i);
            r.last_word   = (3'(i) == LAST_INDEX);
            pending_digest.push_back(r);
        end
        sha1_restart();
    endfunction

    task automatic send_item(input item_t it, input bit known, input logic [159:0] digest);
        int unsigned gap;
        int          base;
        int          n;
        gap = 0;
        roll = $urandom_range(0, 99);
        if (!calm && roll >= 55)
            gap = (roll < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sha1_absorb(it);
        if (known && it.end_of_message)
        begin
            base = pending_digest.size() - 5;
            for (n = 0; n < 5; n++)
                pending_digest[base + n].digest_word = digest[159 - 32*n -: 32];
        end
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (calm)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
            begin
                result_stall <= 1'b0;
            end
            else
            begin
                stall_left = (roll < 92) ? $urandom_range(0, 2) : $urandom_range(10, 50);
                result_stall <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_digest.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected digest word, actual %h index %0d last %b",
                             $time, result.digest_word, result.word_index, result.last_word);
                end
                else
                begin
                    want = pending_digest.pop_front();
                    if (result.digest_word !== want.digest_word)
                    begin
                        errors++;
                        $display("%0t: digest_word expected %h actual %h",
                                 $time, want.digest_word, result.digest_word);
                    end
                    if (result.word_index !== want.word_index)
                    begin
                        errors++;
                        $display("%0t: word_index expected %0d actual %0d",
                                 $time, want.word_index, result.word_index);
                    end
                    if (result.last_word !== want.last_word)
                    begin
                        errors++;
                        $display("%0t: last_word expected %b actual %b",
                                 $time, want.last_word, result.last_word);
                    end
                end
            end
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        item_t it;
        int    row;
        int    sent;
        int    len;
        int    n;
        bit    tail_end;
        errors       = 0;
        idle_cycles  = 0;
        stall_left   = 0;
        calm         = 1'b0;
        item         = '0;
        item_valid   = 1'b0;
        result_stall = 1'b0;
        rst_n        = 1'b0;
        sha1_restart();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (row = 0; row < PLAN_ROWS; row++)
            send_item(PLAN[row].it, PLAN[row].known, PLAN[row].digest);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 4) == 0);
            roll = $urandom_range(0, 9);
            if (roll < 5)
            begin
                len = $urandom_range(0, 12);
            end
            else if (roll < 8)
            begin
                case ($urandom_range(0, 7))
                    0: len = 55;
                    1: len = 56;
                    2: len = 57;
                    3: len = 63;
                    4: len = 64;
                    5: len = 65;
                    6: len = 119;
                    default: len = 120;
                endcase
            end
            else
            begin
                len = $urandom_range(13, 130);
            end
            tail_end = (len == 0) || ($urandom_range(0, 3) == 0);
            for (n = 0; n < len; n++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    it.data_byte      = 8'($urandom);
                    it.byte_valid     = 1'b0;
                    it.end_of_message = 1'b0;
                    send_item(it, 1'b0, '0);
                    sent++;
                end
                it.data_byte      = 8'($urandom);
                it.byte_valid     = 1'b1;
                it.end_of_message = (n == len - 1) && !tail_end;
                send_item(it, 1'b0, '0);
                sent++;
            end
            if (tail_end)
            begin
                it.data_byte      = 8'($urandom);
                it.byte_valid     = 1'b0;
                it.end_of_message = 1'b1;
                send_item(it, 1'b0, '0);
                sent++;
            end
        end
        item_valid <= 1'b0;
        calm = 1'b0;

        while (pending_digest.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_digest.size() != 0)
        begin
            errors++;
            $display("%0t: %0d digest words never arrived", $time, pending_digest.size());
        end
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
design/sha1mh_pkg.sv
design/sha1mh_core.sv
design/sha1_message_hasher_unit.sv
tb/tb_sha1_message_hasher_unit.sv
